>>> rtl/core/rbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants for the region budget and slot table
// Request and response words, request kinds, status codes, controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rbst_pkg;

   // number of region counters and limit registers held in the block
   localparam int NUM_REGIONS = 8;
   localparam int REGION_W    = 3;
   localparam int LIMIT_W     = 23;
   localparam int KB_W        = 23;
   localparam int USED_W      = 32;
   localparam int TOTAL_W     = 35;

   // region charged by slot requests
   localparam logic [REGION_W-1:0] SWAP_REGION = 3'd6;

   // request kinds
   localparam logic [2:0] KIND_ALLOC      = 3'd0;
   localparam logic [2:0] KIND_FREE       = 3'd1;
   localparam logic [2:0] KIND_SLOT_ALLOC = 3'd2;
   localparam logic [2:0] KIND_EVICT      = 3'd3;
   localparam logic [2:0] KIND_RESTORE    = 3'd4;
   localparam logic [2:0] KIND_SLOT_FREE  = 3'd5;

   // response status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_OVER_BUDGET = 3'd1;
   localparam logic [2:0] STATUS_BAD_REGION  = 3'd2;
   localparam logic [2:0] STATUS_NO_SLOT     = 3'd3;
   localparam logic [2:0] STATUS_BAD_SLOT    = 3'd4;

   // limit register values after reset, regions 0..7
   localparam logic [LIMIT_W-1:0] LIMIT_RESET [NUM_REGIONS] = '{
      23'd4096, 23'd2048, 23'd1024, 23'd2048,
      23'd16384, 23'd2048, 23'd4096, 23'd1024
   };

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  region;
      logic [31:0] byte_count;
      logic [4:0]  slot_index;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         slot_granted;
      logic [USED_W-1:0]  region_used_kb;
      logic [TOTAL_W-1:0] total_used_kb;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic read;
      logic calc;
      logic commit;
      logic load_rsp;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

>>> rtl/core/region_budget_and_slot_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_budget_and_slot_table_core: kilobyte region budgets and swap slots
// A request is accepted, then steps through the sequencer's read, decide,
// commit and reply steps; the next request is not accepted until the reply
// has been loaded, and a waiting response stalls only the reply.
// Reset (synchronous, active high): counters, total and slot marks cleared,
// limits at their defaults; slot sizes need no clearing.
// ----------------------------------------------------------------------------
module region_budget_and_slot_table_core #(
   parameter int SLOT_COUNT   = 16,
   parameter int REGION_COUNT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rbst_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rbst_pkg::rsp_word_type rsp_word,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [4:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import rbst_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer
   rbst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // counters, slot table and csr registers
   rbst_datapath #(
      .SLOT_COUNT   (SLOT_COUNT),
      .REGION_COUNT (REGION_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

endmodule

>>> rtl/core/rbst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_ctrl: request sequencer
// Steps one request through read, decide, commit and reply, and holds off
// the next request until the reply has been handed to the output register.
// ----------------------------------------------------------------------------
module rbst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rbst_pkg::dp_stat_type stat,
   output rbst_pkg::ctrl_cmd_type cmd
);
   import rbst_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands, no accept while in reset
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_REPLY;
         end
         ST_REPLY: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/rbst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_datapath: region counters, limit registers and swap slot table
// Holds the usage counters, running total, slot marks and slot sizes, the
// limit registers behind the csr port, and the response output register.
// ----------------------------------------------------------------------------
module rbst_datapath #(
   parameter int SLOT_COUNT   = 16,
   parameter int REGION_COUNT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rbst_pkg::ctrl_cmd_type cmd,
   output rbst_pkg::dp_stat_type  stat,
   input  rbst_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rbst_pkg::rsp_word_type rsp_word,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [4:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import rbst_pkg::*;

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [32:0] KB_ROUND = 33'd1023;

   // limit registers
   logic [LIMIT_W-1:0] limit_ff [NUM_REGIONS];

   // region counters and running total
   logic [USED_W-1:0]  region_used_ff [NUM_REGIONS];
   logic [TOTAL_W-1:0] total_ff;

   // slot table
   logic [SLOT_COUNT-1:0] slot_busy_ff;
   logic [SLOT_COUNT-1:0] slot_resident_ff;
   logic [KB_W-1:0]       slot_kb_ff [SLOT_COUNT];

   // request stage
   req_word_type req_ff;
   logic [KB_W-1:0] kb_ff;
   logic [32:0]     size_round;

   // read stage
   logic [REGION_W-1:0] tgt_ff;
   logic [USED_W-1:0]   used_ff;
   logic [LIMIT_W-1:0]  lim_ff;
   logic [KB_W-1:0]     op_kb_ff;
   logic                found_ff;
   logic [SW-1:0]       free_idx_ff;
   logic                busy_sel_ff;
   logic                res_sel_ff;
   logic [SW-1:0]       slot_sel;
   logic [REGION_W-1:0] tgt_in;
   logic                found_in;
   logic [SW-1:0]       free_idx_in;

   // decide stage
   logic [USED_W-1:0] new_used_ff;
   logic [USED_W-1:0] out_used_ff;
   logic [2:0]        status_ff;
   logic [3:0]        granted_ff;
   logic              op_alloc_ff;
   logic              op_evict_ff;
   logic              op_restore_ff;
   logic              op_release_ff;
   logic [USED_W-1:0] new_used_in;
   logic [USED_W-1:0] out_used_in;
   logic [2:0]        status_in;
   logic [3:0]        granted_in;
   logic              op_alloc_in;
   logic              op_evict_in;
   logic              op_restore_in;
   logic              op_release_in;
   logic [32:0]       sum_kb;
   logic [32:0]       diff_kb;
   logic              fits;
   logic [USED_W-1:0] sat_used;
   logic [USED_W-1:0] floor_used;
   logic              region_ok;
   logic              slot_ok;
   logic [4:0]        idx_wide;

   // output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   // csr port: write in the access cycle, reads straight from the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGIONS; i++) begin
            limit_ff[i] <= LIMIT_RESET[i];
         end
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         limit_ff[csr_paddr[4:2]] <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_prdata = {{(32-LIMIT_W){1'b0}}, limit_ff[csr_paddr[4:2]]};
   assign csr_pready = 1'b1;

   // round the request size up to kilobytes at accept
   assign size_round = {1'b0, req_word.byte_count} + KB_ROUND;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
         kb_ff  <= size_round[32:10];
      end
   end

   // read stage: target region, first free slot, addressed slot
   assign slot_sel = req_ff.slot_index[SW-1:0];

   always_comb begin
      if (req_ff.kind == KIND_ALLOC || req_ff.kind == KIND_FREE) begin
         tgt_in = req_ff.region[REGION_W-1:0];
      end else begin
         tgt_in = SWAP_REGION;
      end
   end

   // first free slot, lowest index wins
   always_comb begin
      found_in    = 1'b0;
      free_idx_in = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!slot_busy_ff[i]) begin
            found_in    = 1'b1;
            free_idx_in = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         tgt_ff      <= tgt_in;
         used_ff     <= region_used_ff[tgt_in];
         lim_ff      <= limit_ff[tgt_in];
         found_ff    <= found_in;
         free_idx_ff <= free_idx_in;
         busy_sel_ff <= slot_busy_ff[slot_sel];
         res_sel_ff  <= slot_resident_ff[slot_sel];
         if (req_ff.kind == KIND_SLOT_FREE) begin
            op_kb_ff <= slot_kb_ff[slot_sel];
         end else begin
            op_kb_ff <= kb_ff;
         end
      end
   end

   // decide stage: budget check, saturating charge, floored refund
   assign sum_kb     = {1'b0, used_ff} + {{(33-KB_W){1'b0}}, op_kb_ff};
   assign diff_kb    = {1'b0, used_ff} - {{(33-KB_W){1'b0}}, op_kb_ff};
   assign fits       = (lim_ff == '0) || (sum_kb <= {{(33-LIMIT_W){1'b0}}, lim_ff});
   assign sat_used   = sum_kb[32] ? '1 : sum_kb[USED_W-1:0];
   assign floor_used = diff_kb[32] ? '0 : diff_kb[USED_W-1:0];
   assign region_ok  = req_ff.region < 4'(REGION_COUNT);
   assign slot_ok    = {1'b0, req_ff.slot_index} < 6'(SLOT_COUNT);
   assign idx_wide   = 5'(free_idx_ff);

   always_comb begin
      new_used_in   = used_ff;
      out_used_in   = '0;
      status_in     = STATUS_OK;
      granted_in    = '0;
      op_alloc_in   = 1'b0;
      op_evict_in   = 1'b0;
      op_restore_in = 1'b0;
      op_release_in = 1'b0;
      case (req_ff.kind)
         KIND_ALLOC: begin
            if (!region_ok) begin
               status_in = STATUS_BAD_REGION;
            end else if (fits) begin
               new_used_in = sat_used;
            end else begin
               status_in = STATUS_OVER_BUDGET;
            end
         end
         KIND_FREE: begin
            if (!region_ok) begin
               status_in = STATUS_BAD_REGION;
            end else begin
               new_used_in = floor_used;
            end
         end
         KIND_SLOT_ALLOC: begin
            if (!region_ok) begin
               status_in = STATUS_BAD_REGION;
            end else if (!fits) begin
               status_in = STATUS_OVER_BUDGET;
            end else if (!found_ff) begin
               status_in = STATUS_NO_SLOT;
            end else begin
               new_used_in = sat_used;
               op_alloc_in = 1'b1;
               granted_in  = idx_wide[3:0];
            end
         end
         KIND_EVICT: begin
            if (!slot_ok) begin
               status_in = STATUS_BAD_SLOT;
            end else begin
               op_evict_in = 1'b1;
            end
         end
         KIND_RESTORE: begin
            if (!slot_ok) begin
               status_in = STATUS_BAD_SLOT;
            end else begin
               op_restore_in = busy_sel_ff;
            end
         end
         KIND_SLOT_FREE: begin
            if (!slot_ok) begin
               status_in = STATUS_BAD_SLOT;
            end else begin
               op_release_in = 1'b1;
               if (res_sel_ff) begin
                  new_used_in = floor_used;
               end
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
      // reported usage: addressed region, swap region for slot kinds
      if (((req_ff.kind == KIND_ALLOC || req_ff.kind == KIND_FREE) && region_ok) ||
          req_ff.kind == KIND_SLOT_ALLOC || req_ff.kind == KIND_EVICT ||
          req_ff.kind == KIND_RESTORE || req_ff.kind == KIND_SLOT_FREE) begin
         out_used_in = new_used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         new_used_ff   <= new_used_in;
         out_used_ff   <= out_used_in;
         status_ff     <= status_in;
         granted_ff    <= granted_in;
         op_alloc_ff   <= op_alloc_in;
         op_evict_ff   <= op_evict_in;
         op_restore_ff <= op_restore_in;
         op_release_ff <= op_release_in;
      end
   end

   // commit stage: counters, total and slot marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGIONS; i++) begin
            region_used_ff[i] <= '0;
         end
         total_ff         <= '0;
         slot_busy_ff     <= '0;
         slot_resident_ff <= '0;
      end else if (cmd.commit) begin
         region_used_ff[tgt_ff] <= new_used_ff;
         total_ff <= total_ff + TOTAL_W'(new_used_ff) - TOTAL_W'(used_ff);
         if (op_alloc_ff) begin
            slot_busy_ff[free_idx_ff]     <= 1'b1;
            slot_resident_ff[free_idx_ff] <= 1'b1;
         end
         if (op_evict_ff) begin
            slot_resident_ff[slot_sel] <= 1'b0;
         end
         if (op_restore_ff) begin
            slot_resident_ff[slot_sel] <= 1'b1;
         end
         if (op_release_ff) begin
            slot_busy_ff[slot_sel]     <= 1'b0;
            slot_resident_ff[slot_sel] <= 1'b0;
         end
      end
   end

   // slot sizes in kilobytes, written on a granted slot alloc
   always_ff @(posedge clock) begin
      if (cmd.commit && op_alloc_ff) begin
         slot_kb_ff[free_idx_ff] <= kb_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_word_ff.status         <= status_ff;
         rsp_word_ff.slot_granted   <= granted_ff;
         rsp_word_ff.region_used_kb <= out_used_ff;
         rsp_word_ff.total_used_kb  <= total_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

endmodule
